FILE: sv/utrp_pkg.sv
// Shared types and constants for the USB transmit ring packetizer.
// Used by utrp_ring_ram, utrp_ctrl and usb_tx_ring_packetizer; no dependencies.
`default_nettype none

package utrp_pkg;

  // Ring geometry; the depth must be a power of two so the indices wrap freely.
  localparam int RING_DEPTH = 512;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int PACKET_MAX = 64;
  localparam int CNT_W      = $clog2(PACKET_MAX + 1);
  localparam int CMP_W      = (PTR_W > CNT_W) ? PTR_W : CNT_W;

  localparam int BYTE_W     = 8;
  localparam int TMO_W      = 10;
  localparam int TIME_W     = 32;
  localparam int DROP_W     = 32;
  localparam int ACT_W      = 3;

  localparam logic [TMO_W-1:0] TMO_RESET = TMO_W'(50);

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUT    = 3'd0,
    ACT_PUMP   = 3'd1,
    ACT_TXDONE = 3'd2,
    ACT_SOF    = 3'd3,
    ACT_TICK   = 3'd4,
    ACT_INIT   = 3'd5,
    ACT_DEINIT = 3'd6
  } utrp_action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STATUS,
    ST_FETCH,
    ST_EMIT
  } utrp_state_e;

  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [PTR_W-1:0]  raddr;
  } ram_req_t;

  typedef struct packed {
    logic              byte_valid;
    logic [BYTE_W-1:0] packet_byte;
    logic              last;
    logic [DROP_W-1:0] dropped_count;
    logic              host_ready;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/utrp_ring_ram.sv
// Byte storage of the transmit ring: one write port, one registered read port.
// Depends on utrp_pkg for the depth and the request struct.
`default_nettype none

module utrp_ring_ram (
  input  wire                          clk_i,
  input  utrp_pkg::ram_req_t           req_i,
  output logic [utrp_pkg::BYTE_W-1:0]  rdata_o
);

  logic [utrp_pkg::BYTE_W-1:0] mem [utrp_pkg::RING_DEPTH];
  logic [utrp_pkg::BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: sv/utrp_ctrl.sv
// Control of the transmit ring: indices, busy flag, drop counter, frame timing
// and the sequencer that reads packets out of the ring. Depends on utrp_pkg.
`default_nettype none

module utrp_ctrl (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_valid_i,
  input  wire  [utrp_pkg::TMO_W-1:0]     cfg_data_i,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire  [utrp_pkg::ACT_W-1:0]     in_action_i,
  input  wire  [utrp_pkg::BYTE_W-1:0]    in_byte_i,
  input  wire                            in_configured_i,
  input  wire                            in_accepts_i,
  input  wire                            out_free_i,
  output logic                           res_load_o,
  output utrp_pkg::result_t              res_o,
  output utrp_pkg::ram_req_t             ram_req_o,
  input  wire  [utrp_pkg::BYTE_W-1:0]    ram_rdata_i
);

  utrp_pkg::utrp_state_e state_q, state_d;

  logic [utrp_pkg::PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d, pos_q, pos_d;
  logic [utrp_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic                        busy_q, busy_d, cfg_q, cfg_d;
  logic [utrp_pkg::DROP_W-1:0] drop_q, drop_d;
  logic [utrp_pkg::TIME_W-1:0] now_q, now_d, sof_q, sof_d;
  logic [utrp_pkg::TMO_W-1:0]  tmo_q;

  logic                        age_ok, ready_pre, ready_now;
  logic                        send_try, busy_v;
  logic [utrp_pkg::PTR_W-1:0]  wr_v, wr_inc, count_v;
  logic [utrp_pkg::CMP_W-1:0]  count_ext;
  logic [utrp_pkg::CNT_W-1:0]  pkt_len;

  // The host counts as present while the last start-of-frame is recent enough.
  assign age_ok    = (now_q - sof_q) < utrp_pkg::TIME_W'(tmo_q);
  assign ready_pre = in_configured_i & age_ok;
  assign ready_now = cfg_q & age_ok;
  assign wr_inc    = wr_q + utrp_pkg::PTR_W'(1);

  always_comb begin
    state_d    = state_q;
    wr_d       = wr_q;
    rd_d       = rd_q;
    pos_d      = pos_q;
    cnt_d      = cnt_q;
    busy_d     = busy_q;
    cfg_d      = cfg_q;
    drop_d     = drop_q;
    now_d      = now_q;
    sof_d      = sof_q;
    in_ready_o = 1'b0;
    res_load_o = 1'b0;
    send_try   = 1'b0;
    busy_v     = busy_q;
    wr_v       = wr_q;
    count_v    = '0;
    count_ext  = '0;
    pkt_len    = '0;
    ram_req_o  = '0;
    res_o.byte_valid    = 1'b0;
    res_o.packet_byte   = '0;
    res_o.last          = 1'b1;
    res_o.dropped_count = drop_q;
    res_o.host_ready    = ready_now;

    case (state_q)
      utrp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cfg_d = in_configured_i;
          case (utrp_pkg::utrp_action_e'(in_action_i))
            utrp_pkg::ACT_PUT: begin
              if (!ready_pre || (wr_inc == rd_q)) begin
                if (drop_q != '1) begin
                  drop_d = drop_q + utrp_pkg::DROP_W'(1);
                end
              end else begin
                ram_req_o.we    = 1'b1;
                ram_req_o.waddr = wr_q;
                ram_req_o.wdata = in_byte_i;
                wr_v            = wr_inc;
                send_try        = 1'b1;
              end
            end
            utrp_pkg::ACT_PUMP: begin
              send_try = 1'b1;
            end
            utrp_pkg::ACT_TXDONE: begin
              busy_v   = 1'b0;
              send_try = 1'b1;
            end
            utrp_pkg::ACT_SOF: begin
              sof_d = now_q;
            end
            utrp_pkg::ACT_TICK: begin
              now_d = now_q + utrp_pkg::TIME_W'(1);
            end
            utrp_pkg::ACT_INIT: begin
              wr_v   = '0;
              rd_d   = '0;
              busy_v = 1'b0;
            end
            utrp_pkg::ACT_DEINIT: begin
              busy_v = 1'b0;
            end
            default: begin
            end
          endcase

          count_v   = wr_v - rd_q;
          count_ext = utrp_pkg::CMP_W'(count_v);
          pkt_len   = (count_ext >= utrp_pkg::CMP_W'(utrp_pkg::PACKET_MAX)) ?
                      utrp_pkg::CNT_W'(utrp_pkg::PACKET_MAX) :
                      utrp_pkg::CNT_W'(count_ext);

          // A refused packet leaves busy clear and the bytes in the ring.
          if (send_try && ready_pre && !busy_v && (wr_v != rd_q) && in_accepts_i) begin
            busy_v  = 1'b1;
            rd_d    = rd_q + utrp_pkg::PTR_W'(pkt_len);
            pos_d   = rd_q;
            cnt_d   = pkt_len;
            state_d = utrp_pkg::ST_FETCH;
          end else begin
            state_d = utrp_pkg::ST_STATUS;
          end
          wr_d   = wr_v;
          busy_d = busy_v;
        end
      end

      utrp_pkg::ST_STATUS: begin
        if (out_free_i) begin
          res_load_o = 1'b1;
          state_d    = utrp_pkg::ST_IDLE;
        end
      end

      utrp_pkg::ST_FETCH: begin
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = pos_q;
        state_d         = utrp_pkg::ST_EMIT;
      end

      utrp_pkg::ST_EMIT: begin
        res_o.byte_valid  = 1'b1;
        res_o.packet_byte = ram_rdata_i;
        res_o.last        = (cnt_q == utrp_pkg::CNT_W'(1));
        if (out_free_i) begin
          res_load_o = 1'b1;
          pos_d      = pos_q + utrp_pkg::PTR_W'(1);
          cnt_d      = cnt_q - utrp_pkg::CNT_W'(1);
          if (cnt_q == utrp_pkg::CNT_W'(1)) begin
            state_d = utrp_pkg::ST_IDLE;
          end else begin
            // The read data register holds while the output stalls, so the
            // next byte is fetched only when the current one leaves.
            ram_req_o.re    = 1'b1;
            ram_req_o.raddr = pos_q + utrp_pkg::PTR_W'(1);
          end
        end
      end

      default: begin
        state_d = utrp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= utrp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      pos_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      cfg_q  <= 1'b0;
      drop_q <= '0;
      now_q  <= '0;
      sof_q  <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      pos_q  <= pos_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      cfg_q  <= cfg_d;
      drop_q <= drop_d;
      now_q  <= now_d;
      sof_q  <= sof_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo_q <= utrp_pkg::TMO_RESET;
    end else if (cfg_valid_i) begin
      tmo_q <= cfg_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: sv/usb_tx_ring_packetizer.sv
// Lossy transmit FIFO for a USB serial endpoint: a 512-byte ring that hands
// packets of up to 64 bytes to the endpoint.
//
// Channels: the slave stream takes one request per item, the action code in
// tuser and the byte, configured and endpoint-accepts flags in tdata. The
// master stream returns results: one per byte of an accepted packet, in ring
// order, or a single status result (tuser low) for any other request. tlast
// marks the final result of each request. The cfg channel writes the
// start-of-frame timeout in millisecond ticks and is always ready.
//
// Sequence: a status request is decided, then its result is loaded. A request
// that sends a packet is decided, the first byte is fetched from the ring memory,
// then one byte per cycle follows off its single read port while the output
// register is free. Requests are handled one at a time; the next one is taken
// once the last result of the current one sits in the output register.
//
// Reset clears the indices, busy flag, drop counter and both time stamps and
// loads a timeout of 50. The ring memory itself is not cleared. When the
// receiver stalls, the output register holds its result and readout pauses.
`default_nettype none

module usb_tx_ring_packetizer (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire  [utrp_pkg::TMO_W-1:0]           cfg_data_i,
  input  wire                                  s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [7:0] data_byte, [8] configured, [9] endpoint_accepts, [15:10] zero
  input  wire  [utrp_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  // [2:0] action
  input  wire  [utrp_pkg::ACT_W-1:0]           s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  wire                                  m_axis_tready_i,
  // [7:0] packet_byte, [39:8] dropped_count, [40] host_ready, [47:41] zero
  output logic [utrp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  output logic                                 m_axis_tlast_o,
  // [0] byte_valid
  output logic                                 m_axis_tuser_o
);

  utrp_pkg::ram_req_t          ram_req;
  logic [utrp_pkg::BYTE_W-1:0] ram_rdata;
  utrp_pkg::result_t           res, out_q, out_d;
  logic                        res_load, out_free;
  logic                        out_valid_q, out_valid_d;

  assign cfg_ready_o = 1'b1;

  utrp_ring_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  utrp_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (s_axis_tvalid_i),
    .in_ready_o      (s_axis_tready_o),
    .in_action_i     (s_axis_tuser_i),
    .in_byte_i       (s_axis_tdata_i[7:0]),
    .in_configured_i (s_axis_tdata_i[8]),
    .in_accepts_i    (s_axis_tdata_i[9]),
    .out_free_i      (out_free),
    .res_load_o      (res_load),
    .res_o           (res),
    .ram_req_o       (ram_req),
    .ram_rdata_i     (ram_rdata)
  );

  // Output register: it can take a new result when empty or being drained.
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_load) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.byte_valid;
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tdata_o  = {7'd0, out_q.host_ready, out_q.dropped_count, out_q.packet_byte};

  // A request moves the sequencer out of idle, so no second one is taken next.
  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("request accepted while the previous one is still in work");

  // The sequencer never overwrites a result that the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> out_free)
    else $error("result loaded into a full output register");

  // A status result is always the only result of its request.
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> m_axis_tlast_o)
    else $error("status result without tlast");

endmodule

`default_nettype wire

FILE: tb/tb_usb_tx_ring_packetizer.sv
// Self-checking testbench for usb_tx_ring_packetizer: stream stimulus, random stalls and a
// scoreboard class that predicts every result from its own copy of the ring state.
// Depends on utrp_pkg and the usb_tx_ring_packetizer RTL only.

module tb_usb_tx_ring_packetizer;
  import utrp_pkg::*;

  localparam logic [ACT_W-1:0] ACT_RSVD = 3'd7;  // not decoded by the block

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 4;

  localparam int unsigned RX_ALWAYS  = 0;
  localparam int unsigned RX_MOSTLY  = 1;
  localparam int unsigned RX_PATTERN = 2;
  localparam int unsigned RX_SPARSE  = 3;

  class tx_ring_scoreboard;
    logic [BYTE_W-1:0] ring [RING_DEPTH];
    logic [PTR_W-1:0]  wr_idx;
    logic [PTR_W-1:0]  rd_idx;
    bit                busy;
    logic [DROP_W-1:0] drops;
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] sof_ms;
    logic [TMO_W-1:0]  sof_tmo;
    logic [BYTE_W-1:0] pkt_q[$];
    result_t           expected_q[$];
    int unsigned       errors, n_requests, n_results, n_packets, max_packet;
    int unsigned       n_refused, n_full_drops;

    function new();
      wr_idx  = '0;
      rd_idx  = '0;
      busy    = 1'b0;
      drops   = '0;
      now_ms  = '0;
      sof_ms  = '0;
      sof_tmo = TMO_RESET;
    endfunction

    function bit host_up(bit cfg);
      logic [TIME_W-1:0] since_sof;
      since_sof = now_ms - sof_ms;
      return cfg && (since_sof < TIME_W'(sof_tmo));
    endfunction

    function void count_drop();
      if (drops != '1) drops = drops + 1'b1;
    endfunction

    // Copies up to one packet out of the ring; a refused packet leaves no bytes behind.
    function void try_packet(bit cfg, bit acc);
      logic [PTR_W-1:0] pos;
      pos = rd_idx;
      if (!host_up(cfg) || busy || wr_idx == rd_idx) return;
      while (pkt_q.size() < PACKET_MAX && pos != wr_idx) begin
        pkt_q.push_back(ring[pos]);
        pos = pos + 1'b1;
      end
      if (acc) begin
        busy   = 1'b1;
        rd_idx = pos;
        n_packets++;
        if (pkt_q.size() > max_packet) max_packet = pkt_q.size();
      end else begin
        pkt_q.delete();
        n_refused++;
      end
    endfunction

    function void note_request(logic [ACT_W-1:0] act, logic [BYTE_W-1:0] data, bit cfg,
                               bit acc);
      logic [PTR_W-1:0] nxt;
      result_t          r;
      bit               ready;
      pkt_q.delete();
      n_requests++;
      case (act)
        ACT_PUT: begin
          nxt = wr_idx + 1'b1;
          if (!host_up(cfg)) begin
            count_drop();
          end else if (nxt == rd_idx) begin
            count_drop();
            n_full_drops++;
          end else begin
            ring[wr_idx] = data;
            wr_idx = nxt;
            try_packet(cfg, acc);
          end
        end
        ACT_PUMP: try_packet(cfg, acc);
        ACT_TXDONE: begin
          busy = 1'b0;
          try_packet(cfg, acc);
        end
        ACT_SOF:  sof_ms = now_ms;
        ACT_TICK: now_ms = now_ms + 1'b1;
        ACT_INIT: begin
          wr_idx = '0;
          rd_idx = '0;
          busy   = 1'b0;
        end
        ACT_DEINIT: busy = 1'b0;
        default: ;
      endcase
      ready = host_up(cfg);
      r.dropped_count = drops;
      r.host_ready    = ready;
      if (pkt_q.size() == 0) begin
        r.byte_valid  = 1'b0;
        r.packet_byte = '0;
        r.last        = 1'b1;
        expected_q.push_back(r);
      end else begin
        foreach (pkt_q[k]) begin
          r.byte_valid  = 1'b1;
          r.packet_byte = pkt_q[k];
          r.last        = (k == pkt_q.size() - 1);
          expected_q.push_back(r);
        end
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      n_results++;
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding: tdata byte %0h", got.packet_byte);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.byte_valid !== want.byte_valid) begin
        $error("byte_valid: expected %0d, got %0d", want.byte_valid, got.byte_valid);
        errors++;
      end
      if (got.packet_byte !== want.packet_byte) begin
        $error("packet_byte: expected %0h, got %0h", want.packet_byte, got.packet_byte);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
      if (got.dropped_count !== want.dropped_count) begin
        $error("dropped_count: expected %0d, got %0d", want.dropped_count, got.dropped_count);
        errors++;
      end
      if (got.host_ready !== want.host_ready) begin
        $error("host_ready: expected %0d, got %0d", want.host_ready, got.host_ready);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i     = 1'b0;
  logic                   rst_ni    = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic [TMO_W-1:0]       cfg_data  = '0;
  logic                   s_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic [ACT_W-1:0]       s_tuser   = '0;
  logic                   m_tready  = 1'b0;
  wire                    cfg_ready;
  wire                    s_tready;
  wire                    m_tvalid;
  wire [OUT_TDATA_W-1:0]  m_tdata;
  wire                    m_tlast;
  wire                    m_tuser;

  tx_ring_scoreboard sb = new();

  int unsigned cycle_cnt  = 0;
  int unsigned burst_left = 0;
  bit          steady_tx  = 1'b0;
  bit          hold_armed = 1'b0;
  bit          hold_taken = 1'b0;
  int unsigned hold_left  = 0;
  int unsigned stall_mode = RX_ALWAYS;
  int unsigned mode_left  = 0;
  int unsigned rx_cyc     = 0;
  logic [7:0]  stall_pat  = 8'hFF;
  result_t     rx_result;

  usb_tx_ring_packetizer i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: checks each accepted result, then picks the next tready from the
  // current stall mode. One long hold-off is taken when the stimulus arms it.
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      rx_result.byte_valid    = m_tuser;
      rx_result.packet_byte   = m_tdata[7:0];
      rx_result.last          = m_tlast;
      rx_result.dropped_count = m_tdata[39:8];
      rx_result.host_ready    = m_tdata[40];
      sb.check_result(rx_result);
    end
    if (hold_armed && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(RX_ALWAYS, RX_SPARSE);
        mode_left  = $urandom_range(20, 80);
        stall_pat  = 8'($urandom) | 8'h01;
      end
      mode_left--;
      rx_cyc++;
      case (stall_mode)
        RX_ALWAYS:  m_tready <= 1'b1;
        RX_MOSTLY:  m_tready <= ($urandom_range(0, 3) != 0);
        RX_PATTERN: m_tready <= stall_pat[rx_cyc % 8];
        default:    m_tready <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  // Offers one request and returns at the edge where it is taken. Requests go out in
  // bursts with idle gaps between them, unless steady_tx keeps the stream full.
  task automatic offer_request(logic [ACT_W-1:0] act, logic [BYTE_W-1:0] data, bit cfg,
                               bit acc);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = steady_tx ? 0 : $urandom_range(0, 6);
      burst_left = $urandom_range(1, 10);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {6'b0, acc, cfg, data};
    do @(posedge clk_i); while (!s_tready);
    sb.note_request(act, data, cfg, acc);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_sof_timeout(logic [TMO_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    sb.sof_tmo = value;
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly well-formed traffic with the device configured; a few requests are
  // fully random noise, the reserved action code included.
  task automatic random_requests(int unsigned count);
    int unsigned      pick;
    logic [ACT_W-1:0] act;
    bit               cfg;
    bit               acc;
    repeat (count) begin
      if ($urandom_range(0, 99) < 8) begin
        act = ACT_W'($urandom);
        cfg = 1'($urandom);
        acc = 1'($urandom);
      end else begin
        cfg  = ($urandom_range(0, 19) != 0);
        acc  = ($urandom_range(0, 3) != 0);
        pick = $urandom_range(0, 99);
        if (pick < 45)      act = ACT_PUT;
        else if (pick < 55) act = ACT_PUMP;
        else if (pick < 70) act = ACT_TXDONE;
        else if (pick < 80) act = ACT_SOF;
        else if (pick < 90) act = ACT_TICK;
        else if (pick < 94) act = ACT_INIT;
        else if (pick < 98) act = ACT_DEINIT;
        else                act = ACT_RSVD;
      end
      offer_request(act, 8'($urandom), cfg, acc);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset timeout: drops while unconfigured, refusal, busy hold, init and deinit.
    offer_request(ACT_DEINIT, 8'h00, 1'b0, 1'b0);
    offer_request(ACT_PUT,    8'h00, 1'b0, 1'b1);
    offer_request(ACT_PUT,    8'hFF, 1'b1, 1'b1);
    offer_request(ACT_PUT,    8'hA5, 1'b1, 1'b1);
    offer_request(ACT_PUT,    8'h5A, 1'b1, 1'b0);
    offer_request(ACT_PUMP,   8'h00, 1'b1, 1'b1);
    offer_request(ACT_TXDONE, 8'h00, 1'b1, 1'b0);
    offer_request(ACT_TXDONE, 8'h00, 1'b1, 1'b1);
    offer_request(ACT_RSVD,   8'hFF, 1'b1, 1'b1);
    offer_request(ACT_TICK,   8'h00, 1'b1, 1'b1);
    offer_request(ACT_SOF,    8'h00, 1'b1, 1'b1);
    offer_request(ACT_PUT,    8'h80, 1'b1, 1'b0);
    offer_request(ACT_INIT,   8'h00, 1'b1, 1'b1);
    offer_request(ACT_PUT,    8'h01, 1'b1, 1'b1);
    offer_request(ACT_DEINIT, 8'h00, 1'b1, 1'b1);
    offer_request(ACT_PUMP,   8'h00, 1'b1, 1'b1);
    wait_drained();

    // Shortest timeout: one tick without start-of-frame takes the host away.
    write_sof_timeout(TMO_W'(1));
    offer_request(ACT_SOF,    8'h00, 1'b1, 1'b1);
    offer_request(ACT_PUT,    8'h7E, 1'b1, 1'b1);
    offer_request(ACT_TICK,   8'h00, 1'b1, 1'b1);
    offer_request(ACT_PUT,    8'h3C, 1'b1, 1'b1);
    offer_request(ACT_SOF,    8'h00, 1'b1, 1'b1);
    offer_request(ACT_PUT,    8'h81, 1'b1, 1'b1);
    offer_request(ACT_TXDONE, 8'h00, 1'b1, 1'b1);
    wait_drained();

    // A zero timeout means the host is never ready.
    write_sof_timeout(TMO_W'(0));
    offer_request(ACT_PUT,    8'hC3, 1'b1, 1'b1);
    offer_request(ACT_SOF,    8'h00, 1'b1, 1'b1);
    offer_request(ACT_PUMP,   8'h00, 1'b1, 1'b1);
    wait_drained();

    // Queue more than a packet with refused sends, then pull a full packet and the rest.
    write_sof_timeout('1);
    offer_request(ACT_INIT, 8'h00, 1'b1, 1'b1);
    offer_request(ACT_SOF,  8'h00, 1'b1, 1'b1);
    repeat (PACKET_MAX + 2) offer_request(ACT_PUT, 8'($urandom), 1'b1, 1'b0);
    offer_request(ACT_PUMP,   8'h00, 1'b1, 1'b1);
    offer_request(ACT_TXDONE, 8'h00, 1'b1, 1'b1);
    offer_request(ACT_DEINIT, 8'h00, 1'b1, 1'b1);
    offer_request(ACT_PUMP,   8'h00, 1'b1, 1'b0);
    offer_request(ACT_TXDONE, 8'h00, 1'b1, 1'b1);
    wait_drained();

    // The result side holds off for a long stretch while requests keep coming.
    hold_armed = 1'b1;
    random_requests(6);
    wait_drained();

    write_sof_timeout(TMO_W'(3));
    steady_tx = 1'b1;
    random_requests(4);
    steady_tx = 1'b0;
    wait_drained();

    write_sof_timeout(TMO_W'($urandom_range(1, 1023)));
    random_requests(3);
    wait_drained();

    write_sof_timeout(TMO_W'(1000));
    random_requests(3);
    wait_drained();

    $display("Run covered %0d requests and %0d results: %0d packets sent (longest %0d bytes),",
             sb.n_requests, sb.n_results, sb.n_packets, sb.max_packet);
    $display("%0d refused by the endpoint, %0d bytes dropped (%0d on a full ring).",
             sb.n_refused, sb.drops, sb.n_full_drops);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
